// ===== src/cfta_pkg.sv =====
// Shared constants and stage types for the cube face texel address pipeline.
package cfta_pkg;

  localparam int MAX_RES_LOG2 = 10;
  localparam int RL_W         = 4;
  localparam int DIR_W        = 16;
  localparam int MAG_W        = DIR_W + 1;
  localparam int DEN_W        = MAG_W + 1;
  localparam int REM_W        = DEN_W + 1;
  localparam int FRAC_BITS    = MAX_RES_LOG2;
  localparam int Q_W          = FRAC_BITS + 1;
  localparam int DIV_STEPS    = FRAC_BITS + 1;
  localparam int STEPS_PER_STG = 2;
  localparam int DIV_STAGES   = (DIV_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;
  localparam int NSTG         = DIV_STAGES + 4;
  localparam int TEX_W        = 10;
  localparam int IDX_W        = 23;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
    logic signed [DIR_W-1:0] dz;
    logic [MAG_W-1:0]        ax;
    logic [MAG_W-1:0]        ay;
    logic [MAG_W-1:0]        az;
    logic [RL_W-1:0]         mip_used;
    logic [RL_W-1:0]         k;
  } abs_stage_t;

  typedef struct packed {
    face_t             face;
    logic              zero;
    logic [RL_W-1:0]   mip_used;
    logic [RL_W-1:0]   k;
    logic [DEN_W-1:0]  den;
    logic [REM_W-1:0]  rx;
    logic [REM_W-1:0]  ry;
    logic [Q_W-1:0]    qx;
    logic [Q_W-1:0]    qy;
  } div_stage_t;

  typedef struct packed {
    face_t             face;
    logic [RL_W-1:0]   mip_used;
    logic [RL_W-1:0]   k;
    logic [TEX_W-1:0]  tx;
    logic [TEX_W-1:0]  ty;
  } tex_stage_t;

endpackage

// ===== src/cube_face_texel_address_core.sv =====
// Cube map face selection and texel addressing, fully pipelined.
//
// Usage:
//   Input words (dir_x, dir_y, dir_z, mip_level) enter on in_valid/in_ready,
//   result words (face, texel_x, texel_y, mip_used, texel_index) leave on
//   out_valid/out_ready. cfg_we writes cfg_res_log2 into the face size
//   register (log2 of base texels per side, saturated at 10); write it only
//   while no words are in flight.
// Timing:
//   Ten register stages: abs/mip clamp, face select, six divider stages of
//   up to two restoring quotient bits each, shift/clamp, index/output register.
//   Throughput is one word per cycle while out_ready is high; a stage that
//   holds a word advances only when the next stage moves.
// Reset:
//   rst clears all stage valid bits and sets the size register to 7.
// Stall:
//   When out_ready is low the output holds; earlier stages keep filling any
//   empty slots, and in_ready drops only once every stage holds a word.
module cube_face_texel_address_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cfta_pkg::RL_W-1:0]          cfg_res_log2,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [cfta_pkg::DIR_W-1:0]  dir_x,
  input  logic signed [cfta_pkg::DIR_W-1:0]  dir_y,
  input  logic signed [cfta_pkg::DIR_W-1:0]  dir_z,
  input  logic [cfta_pkg::RL_W-1:0]          mip_level,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         face,
  output logic [cfta_pkg::TEX_W-1:0]         texel_x,
  output logic [cfta_pkg::TEX_W-1:0]         texel_y,
  output logic [cfta_pkg::RL_W-1:0]          mip_used,
  output logic [cfta_pkg::IDX_W-1:0]         texel_index
);

  localparam int NSTG = cfta_pkg::NSTG;
  localparam int ND   = cfta_pkg::DIV_STAGES;
  localparam int MAGW = cfta_pkg::MAG_W;
  localparam int DENW = cfta_pkg::DEN_W;
  localparam int REMW = cfta_pkg::REM_W;
  localparam int QW   = cfta_pkg::Q_W;
  localparam int TW   = cfta_pkg::TEX_W;
  localparam int IW   = cfta_pkg::IDX_W;
  localparam int RW   = cfta_pkg::RL_W;

  logic [RW-1:0] res_log2;
  logic [RW-1:0] rl;
  logic [NSTG-1:0] v;
  logic [NSTG-1:0] rdy;

  cfta_pkg::abs_stage_t abs_st, abs_next;
  cfta_pkg::div_stage_t dv [0:ND];
  cfta_pkg::div_stage_t sel_next;
  cfta_pkg::div_stage_t dv_next [1:ND];
  cfta_pkg::tex_stage_t tex_st, tex_next;
  logic [IW-1:0] idx_next;

  // one restoring step: {quotient bit, shifted remainder}
  function automatic logic [REMW:0] div_step(input logic [REMW-1:0] r,
                                             input logic [DENW-1:0] d);
    logic [REMW-1:0] dd;
    logic            b;
    logic [REMW-1:0] rr;
    dd = REMW'(d);
    b  = (r >= dd);
    rr = b ? (r - dd) : r;
    return {b, rr[REMW-2:0], 1'b0};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      res_log2 <= RW'(7);
    end else if (cfg_we) begin
      res_log2 <= cfg_res_log2;
    end
  end

  assign rl = (res_log2 > RW'(cfta_pkg::MAX_RES_LOG2)) ? RW'(cfta_pkg::MAX_RES_LOG2)
                                                       : res_log2;

  // backpressure: a stage moves when it is empty or the next one moves
  always_comb begin
    rdy[NSTG-1] = !v[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 0: magnitudes and mip clamp
  always_comb begin
    logic signed [MAGW-1:0] ex, ey, ez;
    logic [RW-1:0]          mu;
    ex = MAGW'(dir_x);
    ey = MAGW'(dir_y);
    ez = MAGW'(dir_z);
    mu = (mip_level < rl) ? mip_level : rl;
    abs_next.dx       = dir_x;
    abs_next.dy       = dir_y;
    abs_next.dz       = dir_z;
    abs_next.ax       = ex[MAGW-1] ? MAGW'(-ex) : MAGW'(ex);
    abs_next.ay       = ey[MAGW-1] ? MAGW'(-ey) : MAGW'(ey);
    abs_next.az       = ez[MAGW-1] ? MAGW'(-ez) : MAGW'(ez);
    abs_next.mip_used = mu;
    abs_next.k        = rl - mu;
  end

  // stage 1: major axis, face, numerators and denominator
  always_comb begin
    logic signed [DENW-1:0] sx, sy, sz, sc, tc, mas, nx, ny;
    logic [MAGW-1:0]        ma;
    logic                   sel_x, sel_y;
    cfta_pkg::face_t        f;
    sx = DENW'(abs_st.dx);
    sy = DENW'(abs_st.dy);
    sz = DENW'(abs_st.dz);
    sel_x = (abs_st.ax >= abs_st.ay) && (abs_st.ax >= abs_st.az);
    sel_y = !sel_x && (abs_st.ay >= abs_st.az);
    if (sel_x) begin
      ma = abs_st.ax;
      tc = -sy;
      if (!abs_st.dx[cfta_pkg::DIR_W-1]) begin
        f  = cfta_pkg::FACE_POS_X;
        sc = -sz;
      end else begin
        f  = cfta_pkg::FACE_NEG_X;
        sc = sz;
      end
    end else if (sel_y) begin
      ma = abs_st.ay;
      sc = sx;
      if (!abs_st.dy[cfta_pkg::DIR_W-1]) begin
        f  = cfta_pkg::FACE_POS_Y;
        tc = sz;
      end else begin
        f  = cfta_pkg::FACE_NEG_Y;
        tc = -sz;
      end
    end else begin
      ma = abs_st.az;
      tc = -sy;
      if (!abs_st.dz[cfta_pkg::DIR_W-1]) begin
        f  = cfta_pkg::FACE_POS_Z;
        sc = sx;
      end else begin
        f  = cfta_pkg::FACE_NEG_Z;
        sc = -sx;
      end
    end
    mas = DENW'(ma);
    nx  = mas + sc;
    ny  = mas + tc;
    sel_next.face     = f;
    sel_next.zero     = (ma == '0);
    sel_next.mip_used = abs_st.mip_used;
    sel_next.k        = abs_st.k;
    sel_next.den      = {ma, 1'b0};
    sel_next.rx       = REMW'(unsigned'(nx));
    sel_next.ry       = REMW'(unsigned'(ny));
    sel_next.qx       = '0;
    sel_next.qy       = '0;
  end

  // divider stages: fraction of num / (2 * ma), MSB first
  always_comb begin
    logic [REMW:0] sx, sy;
    for (int s = 1; s <= ND; s++) begin
      dv_next[s] = dv[s-1];
      for (int j = 0; j < cfta_pkg::STEPS_PER_STG; j++) begin
        if ((s - 1) * cfta_pkg::STEPS_PER_STG + j < cfta_pkg::DIV_STEPS) begin
          sx = div_step(dv_next[s].rx, dv_next[s].den);
          sy = div_step(dv_next[s].ry, dv_next[s].den);
          dv_next[s].rx = sx[REMW-1:0];
          dv_next[s].ry = sy[REMW-1:0];
          dv_next[s].qx = {dv_next[s].qx[QW-2:0], sx[REMW]};
          dv_next[s].qy = {dv_next[s].qy[QW-2:0], sy[REMW]};
        end
      end
    end
  end

  // scale to the mip's resolution, clamp the far edge; a zero vector maps to +X texel (0, 0)
  always_comb begin
    logic [RW-1:0] sh;
    logic [QW-1:0] res, tx, ty;
    sh  = RW'(cfta_pkg::FRAC_BITS) - dv[ND].k;
    res = QW'(1) << dv[ND].k;
    tx  = dv[ND].qx >> sh;
    ty  = dv[ND].qy >> sh;
    if (tx == res) tx = res - QW'(1);
    if (ty == res) ty = res - QW'(1);
    tex_next.mip_used = dv[ND].mip_used;
    tex_next.k        = dv[ND].k;
    if (dv[ND].zero) begin
      tex_next.face = cfta_pkg::FACE_POS_X;
      tex_next.tx   = '0;
      tex_next.ty   = '0;
    end else begin
      tex_next.face = dv[ND].face;
      tex_next.tx   = tx[TW-1:0];
      tex_next.ty   = ty[TW-1:0];
    end
  end

  // tx, ty < res, so the index is a concatenation by shifts
  assign idx_next = (IW'(tex_st.face) << {tex_st.k, 1'b0})
                  | (IW'(tex_st.ty) << tex_st.k)
                  | IW'(tex_st.tx);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      abs_st <= abs_next;
    end
    if (rdy[1]) begin
      dv[0] <= sel_next;
    end
    for (int s = 1; s <= ND; s++) begin
      if (rdy[s+1]) begin
        dv[s] <= dv_next[s];
      end
    end
    if (rdy[NSTG-2]) begin
      tex_st <= tex_next;
    end
    if (rdy[NSTG-1]) begin
      face        <= tex_st.face;
      texel_x     <= tex_st.tx;
      texel_y     <= tex_st.ty;
      mip_used    <= tex_st.mip_used;
      texel_index <= idx_next;
    end
  end

  assign out_valid = v[NSTG-1];

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v))
    else $error("input stalled with an empty stage");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (face <= cfta_pkg::FACE_NEG_Z) && (mip_used <= rl))
    else $error("face or mip out of range");

  a_texel_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((texel_x >> (rl - mip_used)) == '0)
                  && ((texel_y >> (rl - mip_used)) == '0))
    else $error("texel beyond mip resolution");
`endif

endmodule
